>>> rtl/core/binary_morphology_3x3_macros.svh
// Assertion helpers shared by the morphology block.
// Every macro samples on aclk and is disabled while aresetn is low.
`ifndef BINARY_MORPHOLOGY_3X3_MACROS_SVH
`define BINARY_MORPHOLOGY_3X3_MACROS_SVH

// A condition that must hold at every clock edge.
`define BM3_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error("bm3 invariant violated");

// When the antecedent holds, the consequent must hold in the next cycle.
`define BM3_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("bm3 sequence violated");

`endif

>>> rtl/core/bm3_pkg.sv
`timescale 1ns / 1ps

package bm3_pkg;

    // Widest row that the block handles; one lane per column.
    localparam int MAX_WIDTH = 64;
    localparam int MASK_SIDE = 3;
    localparam int MASK_BITS = MASK_SIDE * MASK_SIDE;

    // Configuration register widths.
    localparam int WIDTH_BITS = 7;
    localparam int CFG_DATA_BITS = 9;
    localparam int CFG_INDEX_BITS = 2;

    // Register indexes on the configuration channel.
    localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_WIDTH = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_STRUCT_MASK = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_OP_MODE     = 2'd2;

    // Operation modes.
    localparam logic [1:0] MODE_ERODE  = 2'd0;
    localparam logic [1:0] MODE_DILATE = 2'd1;
    localparam logic [1:0] MODE_OPEN   = 2'd2;
    localparam logic [1:0] MODE_CLOSE  = 2'd3;

    // Register reset values.
    localparam logic [WIDTH_BITS-1:0] RESET_WIDTH = 7'd64;
    localparam logic [MASK_BITS-1:0]  RESET_MASK  = 9'd186;
    localparam logic [1:0]            RESET_MODE  = MODE_OPEN;

    // Output queue: at most three result rows per input row.
    localparam int MAX_RESULTS = 3;
    localparam int QDEPTH = 8;
    localparam int QPTR_BITS = $clog2(QDEPTH);
    localparam int QCNT_BITS = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [MAX_WIDTH-1:0] pixels;
        logic                 last;
    } result_t;

    typedef struct packed {
        logic [1:0]                  count;
        result_t [MAX_RESULTS-1:0]   item;
    } push_t;

endpackage

>>> rtl/core/bm3_lane.sv
`timescale 1ns / 1ps

// One output column: reduces the masked 3x3 neighborhood with AND (erosion)
// or OR (dilation) and forces border columns to zero.
module bm3_lane (
    input  logic [bm3_pkg::MASK_BITS-1:0] nbhd,
    input  logic [bm3_pkg::MASK_BITS-1:0] mask,
    input  logic                          dilate,
    input  logic                          interior,
    output logic                          pixel
);

    logic erode_bit;
    logic dilate_bit;

    // Unmasked taps are neutral for AND and for OR.
    assign erode_bit  = &(nbhd | ~mask);
    assign dilate_bit = |(nbhd & mask);
    assign pixel      = interior & (dilate ? dilate_bit : erode_bit);

endmodule

>>> rtl/core/bm3_pass.sv
`timescale 1ns / 1ps

// One morphology pass over a full row: every column has its own lane.
module bm3_pass (
    input  logic [bm3_pkg::MAX_WIDTH-1:0] above,
    input  logic [bm3_pkg::MAX_WIDTH-1:0] mid,
    input  logic [bm3_pkg::MAX_WIDTH-1:0] below,
    input  logic [bm3_pkg::MASK_BITS-1:0] mask,
    input  logic                          dilate,
    input  logic [bm3_pkg::MAX_WIDTH-1:0] interior,
    output logic [bm3_pkg::MAX_WIDTH-1:0] row_out
);

    // Rows padded with a zero column on each side, so column c sees
    // pad[c], pad[c+1], pad[c+2] as its left, center and right taps.
    logic [bm3_pkg::MAX_WIDTH+1:0] pad_above;
    logic [bm3_pkg::MAX_WIDTH+1:0] pad_mid;
    logic [bm3_pkg::MAX_WIDTH+1:0] pad_below;

    assign pad_above = {1'b0, above, 1'b0};
    assign pad_mid   = {1'b0, mid, 1'b0};
    assign pad_below = {1'b0, below, 1'b0};

    for (genvar c = 0; c < bm3_pkg::MAX_WIDTH; c++) begin : g_lane
        logic [bm3_pkg::MASK_BITS-1:0] nbhd;

        // Bit row*3+col of the mask selects neighbor (y-1+row, x-1+col).
        assign nbhd = {pad_below[c+2], pad_below[c+1], pad_below[c],
                       pad_mid[c+2],   pad_mid[c+1],   pad_mid[c],
                       pad_above[c+2], pad_above[c+1], pad_above[c]};

        bm3_lane u_lane (
            .nbhd     (nbhd),
            .mask     (mask),
            .dilate   (dilate),
            .interior (interior[c]),
            .pixel    (row_out[c])
        );
    end

endmodule

>>> rtl/core/bm3_outq.sv
`timescale 1ns / 1ps
`include "binary_morphology_3x3_macros.svh"

// Result queue: takes up to three rows per cycle and hands them to the
// output channel one per transfer, in order.
module bm3_outq (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  bm3_pkg::push_t                push,
    output logic                          room,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [bm3_pkg::MAX_WIDTH-1:0] m_tdata,
    output logic                          m_tlast
);

    bm3_pkg::result_t                 mem_reg [bm3_pkg::QDEPTH];
    logic [bm3_pkg::QPTR_BITS-1:0]    wr_ptr_reg;
    logic [bm3_pkg::QPTR_BITS-1:0]    wr_ptr_next;
    logic [bm3_pkg::QPTR_BITS-1:0]    rd_ptr_reg;
    logic [bm3_pkg::QPTR_BITS-1:0]    rd_ptr_next;
    logic [bm3_pkg::QCNT_BITS-1:0]    count_reg;
    logic [bm3_pkg::QCNT_BITS-1:0]    count_next;
    logic                             pop;

    assign pop      = m_tvalid & m_tready;
    assign m_tvalid = (count_reg != '0);
    assign m_tdata  = mem_reg[rd_ptr_reg].pixels;
    assign m_tlast  = mem_reg[rd_ptr_reg].last;

    // A new row is taken only when a worst-case burst still fits.
    assign room = (count_reg <= bm3_pkg::QCNT_BITS'(bm3_pkg::QDEPTH - bm3_pkg::MAX_RESULTS));

    always_comb begin
        wr_ptr_next = wr_ptr_reg + bm3_pkg::QPTR_BITS'(push.count);
        rd_ptr_next = rd_ptr_reg + bm3_pkg::QPTR_BITS'(pop);
        count_next  = count_reg + bm3_pkg::QCNT_BITS'(push.count)
                      - bm3_pkg::QCNT_BITS'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < bm3_pkg::MAX_RESULTS; k++) begin
            if (k < int'(push.count)) begin
                mem_reg[bm3_pkg::QPTR_BITS'(wr_ptr_reg + bm3_pkg::QPTR_BITS'(k))]
                    <= push.item[k];
            end
        end
    end

    `BM3_ASSERT_ALWAYS(a_count_bound, count_reg <= bm3_pkg::QCNT_BITS'(bm3_pkg::QDEPTH))
    `BM3_ASSERT_ALWAYS(a_ptr_match, bm3_pkg::QPTR_BITS'(count_reg) == bm3_pkg::QPTR_BITS'(wr_ptr_reg - rd_ptr_reg))
    `BM3_ASSERT_NEXT(a_count_step, 1'b1, count_reg == bm3_pkg::QCNT_BITS'($past(count_reg) + bm3_pkg::QCNT_BITS'($past(push.count)) - bm3_pkg::QCNT_BITS'($past(pop))))

endmodule

>>> rtl/core/binary_morphology_3x3.sv
`timescale 1ns / 1ps
// 3x3 binary morphology on a stream of packed image rows.
// The s_ channel takes one row per transfer: s_tdata bit c is pixel c and
// s_tlast marks the final row of a frame. The m_ channel returns result rows
// in the same packing, with m_tlast on the final result row of each frame.
// The cfg channel writes image_width (index 0), structuring_mask (index 1)
// and operation_mode (index 2: erosion, dilation, opening, closing); other
// indexes are ignored and cfg_ready is always high.
// Latency: a result row caused by an input transfer is presented on the
// m_ channel from the next cycle on. Throughput is one row per cycle: all 64
// columns are worked by parallel lanes, and both passes of opening or
// closing are evaluated in the same cycle from two buffered rows per pass.
// A final row releases up to three results, which drain from an eight-entry
// result queue one per cycle; the row after a frame's top border row emits
// nothing unless it is final, so the burst is absorbed without slowing the input.
// Stalls: s_tready stays high while the queue can hold three more rows; when
// the receiver holds m_tready low the queue fills and s_tready drops.
// Reset (synchronous, aresetn low) empties the queue, clears the row buffers
// and the frame row count, and restores width 64, mask 186 and opening.
module binary_morphology_3x3 (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Input rows.
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [bm3_pkg::MAX_WIDTH-1:0]      s_tdata,   // [63:0] row_pixels
    input  logic                               s_tlast,   // last_row
    // Result rows.
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [bm3_pkg::MAX_WIDTH-1:0]      m_tdata,   // [63:0] out_row_pixels
    output logic                               m_tlast,   // out_last
    // Configuration writes.
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [bm3_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [bm3_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

    // Configuration registers.
    logic [bm3_pkg::WIDTH_BITS-1:0]  width_reg;
    logic [bm3_pkg::MASK_BITS-1:0]   mask_reg;
    logic [1:0]                      mode_reg;

    // Row buffers: newest first. The first pass keeps input rows, the
    // second pass keeps first-pass results.
    logic [bm3_pkg::MAX_WIDTH-1:0]   fp0_reg, fp1_reg, fp0_next, fp1_next;
    logic [bm3_pkg::MAX_WIDTH-1:0]   sp0_reg, sp1_reg, sp0_next, sp1_next;
    logic [1:0]                      rows_seen_reg, rows_seen_next;

    logic                            accept;
    logic                            room;
    logic                            two_pass;
    logic                            first_dil;
    logic                            second_dil;
    logic                            have_p;
    logic [bm3_pkg::WIDTH_BITS-1:0]  width_eff;
    logic [bm3_pkg::MAX_WIDTH-1:0]   interior;
    logic [bm3_pkg::MAX_WIDTH-1:0]   p_row;
    logic [bm3_pkg::MAX_WIDTH-1:0]   full_row;
    logic [bm3_pkg::MAX_WIDTH-1:0]   tail_row;
    bm3_pkg::push_t                  push;

    assign cfg_ready = 1'b1;
    assign s_tready  = room;
    assign accept    = s_tvalid & s_tready;

    // Configuration writes land directly; the next computed row uses them.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg <= bm3_pkg::RESET_WIDTH;
            mask_reg  <= bm3_pkg::RESET_MASK;
            mode_reg  <= bm3_pkg::RESET_MODE;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                bm3_pkg::REG_IMAGE_WIDTH: width_reg <= cfg_data[bm3_pkg::WIDTH_BITS-1:0];
                bm3_pkg::REG_STRUCT_MASK: mask_reg  <= cfg_data;
                bm3_pkg::REG_OP_MODE:     mode_reg  <= cfg_data[1:0];
                default: begin
                end
            endcase
        end
    end

    assign two_pass   = (mode_reg == bm3_pkg::MODE_OPEN) || (mode_reg == bm3_pkg::MODE_CLOSE);
    assign first_dil  = (mode_reg == bm3_pkg::MODE_DILATE) || (mode_reg == bm3_pkg::MODE_CLOSE);
    assign second_dil = (mode_reg == bm3_pkg::MODE_OPEN);
    assign have_p     = rows_seen_reg[1];

    // Interior columns run from 1 to width-2; wider settings clamp to the
    // row size, and widths below three leave no interior at all.
    assign width_eff = (width_reg > bm3_pkg::WIDTH_BITS'(bm3_pkg::MAX_WIDTH))
                       ? bm3_pkg::WIDTH_BITS'(bm3_pkg::MAX_WIDTH) : width_reg;

    always_comb begin
        for (int c = 0; c < bm3_pkg::MAX_WIDTH; c++) begin
            interior[c] = (c != 0) &&
                          ((8'(c) + 8'd2) <= {1'b0, width_eff});
        end
    end

    // First pass on the row centered one row back.
    bm3_pass u_pass_first (
        .above    (fp1_reg),
        .mid      (fp0_reg),
        .below    (s_tdata),
        .mask     (mask_reg),
        .dilate   (first_dil),
        .interior (interior),
        .row_out  (p_row)
    );

    // Second pass in steady state, centered two rows back.
    bm3_pass u_pass_full (
        .above    (sp1_reg),
        .mid      (sp0_reg),
        .below    (p_row),
        .mask     (mask_reg),
        .dilate   (second_dil),
        .interior (interior),
        .row_out  (full_row)
    );

    // Second pass at frame end, with a zero row below.
    bm3_pass u_pass_tail (
        .above    (sp0_reg),
        .mid      (p_row),
        .below    ('0),
        .mask     (mask_reg),
        .dilate   (second_dil),
        .interior (interior),
        .row_out  (tail_row)
    );

    // Gather the results of this row in order into consecutive slots.
    always_comb begin
        logic [1:0] n;
        n = 2'd0;
        push.item = '0;
        if (rows_seen_reg == 2'd0) begin
            // The top border row leaves at once.
            push.item[n] = '{pixels: '0, last: s_tlast};
            n = n + 2'd1;
        end else if (!two_pass) begin
            if (have_p) begin
                push.item[n] = '{pixels: p_row, last: 1'b0};
                n = n + 2'd1;
            end
            if (s_tlast) begin
                push.item[n] = '{pixels: '0, last: 1'b1};
                n = n + 2'd1;
            end
        end else begin
            if (rows_seen_reg == 2'd3) begin
                push.item[n] = '{pixels: full_row, last: 1'b0};
                n = n + 2'd1;
            end
            if (s_tlast) begin
                if (have_p) begin
                    push.item[n] = '{pixels: tail_row, last: 1'b0};
                    n = n + 2'd1;
                end
                push.item[n] = '{pixels: '0, last: 1'b1};
                n = n + 2'd1;
            end
        end
        push.count = accept ? n : 2'd0;
    end

    always_comb begin
        fp1_next = fp0_reg;
        fp0_next = s_tdata;
        sp0_next = sp0_reg;
        sp1_next = sp1_reg;
        // A new frame starts the second pass from zero rows.
        if (rows_seen_reg == 2'd0) begin
            sp0_next = '0;
            sp1_next = '0;
        end else if (two_pass && have_p) begin
            sp1_next = sp0_reg;
            sp0_next = p_row;
        end
        if (s_tlast) begin
            rows_seen_next = 2'd0;
        end else if (rows_seen_reg != 2'd3) begin
            rows_seen_next = rows_seen_reg + 2'd1;
        end else begin
            rows_seen_next = rows_seen_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fp0_reg       <= '0;
            fp1_reg       <= '0;
            sp0_reg       <= '0;
            sp1_reg       <= '0;
            rows_seen_reg <= 2'd0;
        end else if (accept) begin
            fp0_reg       <= fp0_next;
            fp1_reg       <= fp1_next;
            sp0_reg       <= sp0_next;
            sp1_reg       <= sp1_next;
            rows_seen_reg <= rows_seen_next;
        end
    end

    bm3_outq u_outq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .room     (room),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

>>> bench/bm3_checker.sv
`timescale 1ns / 1ps

// Watches the row, result and configuration channels of the morphology block,
// predicts every result row and compares it with what the block returns.
module bm3_checker
    import bm3_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    input  logic                      s_tready,
    input  logic [MAX_WIDTH-1:0]      s_tdata,
    input  logic                      s_tlast,
    input  logic                      m_tvalid,
    input  logic                      m_tready,
    input  logic [MAX_WIDTH-1:0]      m_tdata,
    input  logic                      m_tlast,
    input  logic                      cfg_valid,
    input  logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    output int                        fail_count,
    output int                        rows_pending
);

    // Shadow copy of the configuration registers.
    logic [WIDTH_BITS-1:0] width_q;
    logic [MASK_BITS-1:0]  mask_q;
    logic [1:0]            mode_q;

    // Line buffers: raw input rows and first-pass rows, newest in entry 0.
    logic [MAX_WIDTH-1:0]  raw_rows [2];
    logic [MAX_WIDTH-1:0]  pass1_rows [2];
    logic [1:0]            frame_row;

    result_t               expected_rows [$];
    result_t               oldest;
    int                    mismatches = 0;
    int                    pending_q = 0;

    assign fail_count   = mismatches;
    assign rows_pending = pending_q;

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t ns: %s", $time, what);
        mismatches++;
    endtask

    task automatic queue_result(input logic [MAX_WIDTH-1:0] px, input logic lst);
        result_t entry;
        entry.pixels = px;
        entry.last   = lst;
        expected_rows.push_back(entry);
    endtask

    // Columns 1 .. width-2; widths past the maximum count as the maximum.
    function automatic logic [MAX_WIDTH-1:0] interior_cols(input logic [WIDTH_BITS-1:0] w);
        logic [WIDTH_BITS-1:0] wc;
        wc = (w > MAX_WIDTH) ? WIDTH_BITS'(MAX_WIDTH) : w;
        if (wc < 3) return '0;
        return ((64'd1 << (wc - 1)) - 64'd1) & ~64'd1;
    endfunction

    // One erosion (grow low) or dilation (grow high) pass over a 3-row window.
    function automatic logic [MAX_WIDTH-1:0] window_op(input logic [MAX_WIDTH-1:0] above,
                                                       input logic [MAX_WIDTH-1:0] mid,
                                                       input logic [MAX_WIDTH-1:0] below,
                                                       input logic grow);
        logic [MAX_WIDTH-1:0] lines [3];
        logic [MAX_WIDTH-1:0] acc;
        logic [MAX_WIDTH-1:0] nb;
        lines[0] = above;
        lines[1] = mid;
        lines[2] = below;
        acc = grow ? '0 : '1;
        for (int r = 0; r < MASK_SIDE; r++) begin
            for (int c = 0; c < MASK_SIDE; c++) begin
                if (mask_q[r * MASK_SIDE + c]) begin
                    case (c)
                        0: begin
                            nb = lines[r] << 1;
                        end
                        1: begin
                            nb = lines[r];
                        end
                        default: begin
                            nb = lines[r] >> 1;
                        end
                    endcase
                    acc = grow ? (acc | nb) : (acc & nb);
                end
            end
        end
        return acc & interior_cols(width_q);
    endfunction

    task automatic predict_row(input logic [MAX_WIDTH-1:0] row, input logic lst);
        logic                 two_pass;
        logic                 first_grow;
        logic                 second_grow;
        logic                 have_p;
        logic [MAX_WIDTH-1:0] p;
        logic [1:0]           r;
        two_pass    = (mode_q == MODE_OPEN) || (mode_q == MODE_CLOSE);
        first_grow  = (mode_q == MODE_DILATE) || (mode_q == MODE_CLOSE);
        second_grow = (mode_q == MODE_OPEN);
        r = frame_row;
        have_p = (r >= 2);
        p = '0;
        if (r == 0) begin
            pass1_rows[0] = '0;
            pass1_rows[1] = '0;
        end
        if (have_p) p = window_op(raw_rows[1], raw_rows[0], row, first_grow);
        if (!two_pass) begin
            if (r == 0) begin
                queue_result('0, lst);
            end else begin
                if (have_p) queue_result(p, 1'b0);
                if (lst) queue_result('0, 1'b1);
            end
        end else begin
            if (r == 0) begin
                queue_result('0, lst);
            end else begin
                if (r == 3) queue_result(window_op(pass1_rows[1], pass1_rows[0], p, second_grow), 1'b0);
                if (lst) begin
                    if (have_p) queue_result(window_op(pass1_rows[0], p, '0, second_grow), 1'b0);
                    queue_result('0, 1'b1);
                end
            end
            if (have_p) begin
                pass1_rows[1] = pass1_rows[0];
                pass1_rows[0] = p;
            end
        end
        raw_rows[1] = raw_rows[0];
        raw_rows[0] = row;
        if (lst) frame_row = 2'd0;
        else if (r < 3) frame_row = r + 2'd1;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            width_q = RESET_WIDTH;
            mask_q  = RESET_MASK;
            mode_q  = RESET_MODE;
            raw_rows[0] = '0;
            raw_rows[1] = '0;
            pass1_rows[0] = '0;
            pass1_rows[1] = '0;
            frame_row = 2'd0;
            expected_rows.delete();
        end else begin
            // Results come at the earliest in the cycle after their row, so check first.
            if (m_tvalid && m_tready) begin
                if (expected_rows.size() == 0) begin
                    report_mismatch($sformatf("unexpected result row %h last %b", m_tdata, m_tlast));
                end else begin
                    oldest = expected_rows.pop_front();
                    if (m_tdata !== oldest.pixels)
                        report_mismatch($sformatf("row pixels %h, predicted %h",
                                                  m_tdata, oldest.pixels));
                    if (m_tlast !== oldest.last)
                        report_mismatch($sformatf("last flag %b, predicted %b",
                                                  m_tlast, oldest.last));
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_IMAGE_WIDTH: begin
                        width_q = cfg_data[WIDTH_BITS-1:0];
                    end
                    REG_STRUCT_MASK: begin
                        mask_q = cfg_data[MASK_BITS-1:0];
                    end
                    REG_OP_MODE: begin
                        mode_q = cfg_data[1:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (s_tvalid && s_tready) predict_row(s_tdata, s_tlast);
        end
        pending_q = expected_rows.size();
    end

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the 3x3 binary morphology block. The checker beside
// the block does all prediction and comparison; this module only produces row
// frames and configuration writes, paces both sides of the stream, and decides
// the outcome once every predicted row has come back.
module tb_top;
    import bm3_pkg::*;

    // The configuration channel has one index past the register list; writes
    // to it must be ignored by the block.
    localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED = 2'd3;

    localparam int RANDOM_ROWS  = 180;
    localparam int PHASE_ROWS   = 45;
    // A row causes its results from the next cycle on; SETTLE_CYCLES of quiet
    // let the block settle after the last expected transfer.
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_CYCLES  = 10;
    // The limit leaves a wide margin over the slowest legal run.
    localparam int CYCLE_LIMIT   = 200000;

    logic                      aclk = 1'b0;
    logic                      aresetn;
    logic                      s_tvalid;
    logic                      s_tready;
    logic [MAX_WIDTH-1:0]      s_tdata;   // [63:0] row_pixels
    logic                      s_tlast;   // last_row
    logic                      m_tvalid;
    logic                      m_tready;
    logic [MAX_WIDTH-1:0]      m_tdata;   // [63:0] out_row_pixels
    logic                      m_tlast;   // out_last
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;

    int fail_count;
    int rows_pending;

    // Idle and stall odds in percent, changed per traffic phase.
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int rows_sent = 0;
    int cycle_count = 0;

    always #1 aclk = ~aclk;

    binary_morphology_3x3 DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    bm3_checker u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tlast      (s_tlast),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .rows_pending (rows_pending)
    );

    // The receiver decides afresh at every falling edge whether to stall.
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Watchdog: a hung handshake or a missing result ends the run here.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // A row picture with a random density, so that erosion and dilation both
    // see full, empty and mixed neighborhoods.
    function automatic logic [MAX_WIDTH-1:0] random_row();
        logic [MAX_WIDTH-1:0] a;
        logic [MAX_WIDTH-1:0] b;
        a = {$urandom, $urandom};
        b = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0: begin
                return '1;
            end
            1: begin
                return '0;
            end
            2: begin
                return a & b;
            end
            3: begin
                return a | b;
            end
            default: begin
                return a;
            end
        endcase
    endfunction

    // Offers one row, after a random idle gap, and returns at the falling edge
    // that follows its transfer. The valid stays high for a following row.
    task automatic send_row(input logic [MAX_WIDTH-1:0] px, input logic lst);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        s_tlast  <= lst;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        rows_sent++;
    endtask

    // One register transfer; the caller lowers cfg_valid after the last one.
    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
    endtask

    // Registers change only while the block is quiet: the row stream is paused,
    // every predicted row has been returned and SETTLE_CYCLES have passed. The
    // unused bits of the width and mode words carry random values, which must not matter.
    task automatic configure(input logic [WIDTH_BITS-1:0] w, input logic [MASK_BITS-1:0] msk,
                             input logic [1:0] md, input logic poke_unused);
        s_tvalid <= 1'b0;
        while (rows_pending != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
        write_reg(REG_IMAGE_WIDTH, {2'($urandom_range(0, 3)), w});
        write_reg(REG_STRUCT_MASK, msk);
        write_reg(REG_OP_MODE, {7'($urandom_range(0, 127)), md});
        if (poke_unused) write_reg(REG_UNUSED, CFG_DATA_BITS'($urandom_range(0, 511)));
        cfg_valid <= 1'b0;
    endtask

    initial begin
        int frame_len;
        int phase;
        logic [WIDTH_BITS-1:0] w;
        logic [MASK_BITS-1:0]  msk;

        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tlast   = 1'b0;
        m_tready  = 1'b1;
        cfg_valid = 1'b0;
        cfg_index = REG_IMAGE_WIDTH;
        cfg_data  = '0;
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed frames. The first one runs on the reset settings: width 64,
        // cross-shaped mask and opening.
        send_row('1, 1'b0);
        send_row('1, 1'b0);
        send_row('1, 1'b0);
        send_row(64'h5555_5555_5555_5555, 1'b1);
        // Frames of one and of two rows consist of border rows only.
        send_row('1, 1'b1);
        send_row('1, 1'b0);
        send_row('1, 1'b1);
        // An empty mask: erosion fills the interior even from a blank image,
        // and the write to the index past the register list is ignored.
        configure(7'd64, 9'd0, MODE_ERODE, 1'b1);
        send_row('0, 1'b0);
        send_row('0, 1'b0);
        send_row('0, 1'b1);
        // Dilation with an empty mask sets nothing.
        configure(7'd64, 9'd0, MODE_DILATE, 1'b0);
        send_row('1, 1'b0);
        send_row('1, 1'b0);
        send_row('1, 1'b1);
        // Narrowest legal width with the full mask: a single interior column,
        // while the bits above the width must never reach a result.
        configure(7'd3, 9'h1FF, MODE_DILATE, 1'b0);
        send_row(64'hFFFF_FFFF_FFFF_FFF2, 1'b0);
        send_row(64'h5, 1'b0);
        send_row('0, 1'b1);
        // Width past the maximum acts as 64; the mask changes in mid-frame and
        // must apply from the next computed row on.
        configure(7'd127, 9'h1FF, MODE_CLOSE, 1'b0);
        send_row(random_row(), 1'b0);
        send_row(random_row(), 1'b0);
        configure(7'd127, 9'h0AA, MODE_CLOSE, 1'b0);
        send_row(random_row(), 1'b0);
        send_row(random_row(), 1'b0);
        send_row(random_row(), 1'b1);
        // Width below three leaves no interior column at all.
        configure(7'd2, RESET_MASK, MODE_OPEN, 1'b0);
        send_row('1, 1'b0);
        send_row('1, 1'b0);
        send_row('1, 1'b1);

        // Random frames. Most have at least three rows so that both passes get
        // past their border rows; a few are one or two rows long, and a few are
        // interrupted by a register write. Traffic phases rotate every few
        // dozen rows: no idling, idle sender, stalling receiver, and both.
        rows_sent = 0;
        while (rows_sent < RANDOM_ROWS) begin
            phase = (rows_sent / PHASE_ROWS) % 4;
            send_idle_pct  = (phase == 1) ? 54 : (phase == 3) ? 8 : 0;
            recv_stall_pct = (phase == 2) ? 54 : (phase == 3) ? 8 : 0;
            if ($urandom_range(0, 99) < 35) begin
                case ($urandom_range(0, 5))
                    0: w = 7'd3;
                    1: w = 7'd64;
                    2: w = 7'($urandom_range(0, 2));
                    3: w = 7'($urandom_range(65, 127));
                    default: w = 7'($urandom_range(3, 64));
                endcase
                case ($urandom_range(0, 5))
                    0: msk = 9'd0;
                    1: msk = 9'h1FF;
                    2: msk = RESET_MASK;
                    default: msk = 9'($urandom_range(0, 511));
                endcase
                configure(w, msk, 2'($urandom_range(0, 3)), ($urandom_range(0, 9) == 0));
            end
            frame_len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 9);
            for (int k = 0; k < frame_len; k++) begin
                if (k > 0 && $urandom_range(0, 99) < 3)
                    configure(7'($urandom_range(0, 127)), 9'($urandom_range(0, 511)),
                              2'($urandom_range(0, 3)), 1'b0);
                send_row(random_row(), (k == frame_len - 1));
            end
        end

        s_tvalid <= 1'b0;
        while (rows_pending != 0) @(negedge aclk);
        // Anything the block sends after this point is an unexpected row.
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
